FILE: rtl/core/key_bitmap_scanner_with_repeat_assert.svh
// ----------------------------------------------------------------------------
// Key bitmap scanner assertion macros
// Shared property forms for the scanner's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef KEY_BITMAP_SCANNER_WITH_REPEAT_ASSERT_SVH
`define KEY_BITMAP_SCANNER_WITH_REPEAT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define KBS_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define KBS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition never holds.
`define KBS_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/core/kbs_pkg.sv
// ----------------------------------------------------------------------------
// kbs_pkg
// Types, constants and the scancode translation table of the key scanner.
// ----------------------------------------------------------------------------
package kbs_pkg;

   localparam int KEYS_PER_BLOCK = 32;
   localparam int KEY_BIT_W      = 5;
   localparam int BLOCK_W        = 3;
   localparam int SCAN_W         = 8;
   localparam int INTERVAL_W     = 16;
   localparam int NOW_W          = 32;

   localparam logic [INTERVAL_W-1:0] REPEAT_RESET = 16'd400;

   localparam logic [7:0] VK_ENTER     = 8'h0D;
   localparam logic [7:0] VK_BACKSPACE = 8'h08;
   localparam logic [7:0] VK_TAB       = 8'h09;
   localparam logic [7:0] VK_ESC       = 8'h1B;
   localparam logic [7:0] VK_SPACE     = 8'h20;
   localparam logic [7:0] VK_DIGIT_LO  = 8'h30;
   localparam logic [7:0] VK_DIGIT_HI  = 8'h39;
   localparam logic [7:0] VK_ALPHA_LO  = 8'h41;
   localparam logic [7:0] VK_ALPHA_HI  = 8'h5A;
   localparam logic [7:0] VK_ARROW_LO  = 8'h25;
   localparam logic [7:0] VK_ARROW_HI  = 8'h28;

   localparam logic [KEY_BIT_W-1:0] LAST_KEY_BIT = 5'd31;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_WALK,
      SCAN_FLUSH
   } scan_state_type;

   typedef struct packed {
      logic        key_valid;
      logic [7:0]  key_code;
      logic        is_ascii;
      logic [7:0]  scan_code;
      logic        last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] code;
      logic       ascii;
   } key_map_type;

   localparam logic [7:0] SCAN_TO_VK [256] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
      8'hBD, 8'hBB,
      8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50,
      8'hDB, 8'hDD, 8'h0D,
      8'hA2, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hBA, 8'hDE,
      8'hC0, 8'hA0, 8'hDC,
      8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'hBC, 8'hBE, 8'hBF, 8'hA1, 8'h6A,
      8'hA4, 8'h20, 8'h14,
      8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h13, 8'h91,
      8'h24, 8'h26, 8'h21,
      8'h6D, 8'h25, 8'h0C, 8'h27, 8'h6B, 8'h23, 8'h28, 8'h22, 8'h2D, 8'h2E, 8'h2C, 8'h00,
      8'hE2, 8'h7A, 8'h7B,
      8'h0C, 8'hEE, 8'hF1, 8'hEA, 8'hF9, 8'hF5, 8'hF3, 8'h00, 8'h00, 8'hFB, 8'h2F, 8'h7C,
      8'h7D, 8'h7E, 8'h7F,
      8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'hED, 8'h00, 8'hE9, 8'h00, 8'hC1,
      8'h00, 8'h00, 8'h87,
      8'h00, 8'h00, 8'h00, 8'h00, 8'hEB, 8'h09, 8'h00, 8'hC2, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hB1, 8'h00,
      8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'hB0, 8'h00, 8'h00, 8'h0D, 8'hA3, 8'h00, 8'h00, 8'hAD,
      8'hB6, 8'hB3, 8'h00,
      8'hB2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAE, 8'h00,
      8'hAF, 8'h00, 8'hB7,
      8'h00, 8'h00, 8'hBF, 8'h00, 8'h2A, 8'hA5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h90, 8'h00, 8'h24, 8'h26, 8'h21, 8'h00, 8'h25, 8'h00, 8'h27,
      8'h00, 8'h23, 8'h28,
      8'h22, 8'h2D, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5B, 8'h5C,
      8'h5D, 8'h00, 8'h5F,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA, 8'hAB, 8'hA8, 8'hA9, 8'hA7, 8'hA6, 8'hAC,
      8'hB4, 8'hB5, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00,
      8'h00, 8'h00
   };

   // Map a scancode to its queued key; hit is low for keys that are dropped.
   function automatic key_map_type map_scan_code(input logic [SCAN_W-1:0] sc);
      logic [7:0]  vk;
      key_map_type res;
      vk        = SCAN_TO_VK[sc];
      res.code  = vk;
      res.hit   = 1'b0;
      res.ascii = 1'b0;
      if ((vk == VK_ENTER) || (vk == VK_BACKSPACE) || (vk == VK_TAB) ||
          (vk == VK_ESC) || (vk == VK_SPACE) ||
          ((vk >= VK_DIGIT_LO) && (vk <= VK_DIGIT_HI)) ||
          ((vk >= VK_ALPHA_LO) && (vk <= VK_ALPHA_HI))) begin
         res.hit   = 1'b1;
         res.ascii = 1'b1;
      end else if ((vk >= VK_ARROW_LO) && (vk <= VK_ARROW_HI)) begin
         res.hit   = 1'b1;
      end
      return res;
   endfunction

endpackage

FILE: rtl/core/kbs_time_mem.sv
// ----------------------------------------------------------------------------
// kbs_time_mem
// Per-key last-fire time store: one write and one registered read per cycle,
// with a valid bit per entry so that an entry never written reads as zero.
// ----------------------------------------------------------------------------
module kbs_time_mem #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              wr_set
);

   logic [DATA_W-1:0] time_mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_word_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= time_mem[rd_addr];
      end
   end

   // A cleared key drops its valid bit and reads back as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= wr_set;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

FILE: rtl/core/kbs_scan.sv
// ----------------------------------------------------------------------------
// kbs_scan
// Key walker: steps through the 32 keys of a block, one time-store access per
// key, decides fires and holds the newest keypress until the next one shows.
// ----------------------------------------------------------------------------
`include "key_bitmap_scanner_with_repeat_assert.svh"

module kbs_scan #(
   parameter int NUM_BLOCKS = 8,
   parameter int TIME_BITS  = 32,
   parameter int ADDR_W     = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [kbs_pkg::BLOCK_W-1:0]        req_block,
   input  logic [kbs_pkg::KEYS_PER_BLOCK-1:0] req_word,
   input  logic [kbs_pkg::NOW_W-1:0]          req_now,
   input  logic [kbs_pkg::INTERVAL_W-1:0]     interval,
   input  logic                               slot_free,
   output logic                               push,
   output kbs_pkg::rsp_item_type              push_item,
   output logic                               mem_rd_en,
   output logic [ADDR_W-1:0]                  mem_rd_addr,
   input  logic [TIME_BITS-1:0]               mem_rd_data,
   output logic                               mem_wr_en,
   output logic [ADDR_W-1:0]                  mem_wr_addr,
   output logic [TIME_BITS-1:0]               mem_wr_data,
   output logic                               mem_wr_set
);

   localparam int PBLK_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

   kbs_pkg::scan_state_type state_ff, state_in;

   logic [kbs_pkg::BLOCK_W-1:0]        blk_ff, blk_in;
   logic [kbs_pkg::KEYS_PER_BLOCK-1:0] cur_ff, cur_in;
   logic [kbs_pkg::KEYS_PER_BLOCK-1:0] prev_ff, prev_in;
   logic [TIME_BITS-1:0]               now_ff, now_in;
   logic [kbs_pkg::KEY_BIT_W-1:0]      bit_ff, bit_in;
   logic                               pend_valid_ff, pend_valid_in;
   kbs_pkg::rsp_item_type              pend_ff, pend_in;
   logic [kbs_pkg::KEYS_PER_BLOCK-1:0] prev_bits_ff [NUM_BLOCKS];
   logic                               prev_wr;

   logic                        in_range;
   logic                        down, was, too_soon, fire, emit, advance;
   logic [TIME_BITS-1:0]        elapsed;
   logic [kbs_pkg::SCAN_W-1:0]  scan_code;
   kbs_pkg::key_map_type        map;

   assign in_range  = ({1'b0, req_block} < 4'(NUM_BLOCKS));
   assign scan_code = {blk_ff, bit_ff};
   assign down      = cur_ff[bit_ff];
   assign was       = prev_ff[bit_ff];
   assign elapsed   = now_ff - mem_rd_data;
   assign too_soon  = was && (elapsed < TIME_BITS'(interval));
   assign fire      = down && !too_soon;
   assign map       = kbs_pkg::map_scan_code(scan_code);
   assign emit      = fire && map.hit;
   // A second keypress must push the held one out first.
   assign advance   = !(emit && pend_valid_ff) || slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kbs_pkg::SCAN_IDLE;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff  <= blk_in;
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      now_ff  <= now_in;
      bit_ff  <= bit_in;
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            prev_bits_ff[i] <= '0;
         end
      end else if (prev_wr) begin
         prev_bits_ff[blk_ff[PBLK_W-1:0]] <= cur_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      blk_in        = blk_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      now_in        = now_ff;
      bit_in        = bit_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      prev_wr       = 1'b0;
      req_ready     = 1'b0;
      push          = 1'b0;
      push_item     = pend_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = ADDR_W'({blk_ff, bit_ff + 5'd1});
      mem_wr_en     = 1'b0;
      mem_wr_addr   = ADDR_W'(scan_code);
      mem_wr_data   = now_ff;
      mem_wr_set    = 1'b0;

      unique case (state_ff)
         kbs_pkg::SCAN_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               blk_in = req_block;
               cur_in = req_word;
               now_in = TIME_BITS'(req_now);
               bit_in = '0;
               if (in_range) begin
                  prev_in     = prev_bits_ff[req_block[PBLK_W-1:0]];
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ADDR_W'({req_block, 5'd0});
                  state_in    = kbs_pkg::SCAN_WALK;
               end else begin
                  state_in = kbs_pkg::SCAN_FLUSH;
               end
            end
         end

         kbs_pkg::SCAN_WALK: begin
            if (advance) begin
               if (!down && was) begin
                  mem_wr_en  = 1'b1;
                  mem_wr_set = 1'b0;
               end else if (fire) begin
                  mem_wr_en  = 1'b1;
                  mem_wr_set = 1'b1;
               end
               if (emit) begin
                  push          = pend_valid_ff;
                  push_item     = pend_ff;
                  pend_valid_in = 1'b1;
                  pend_in       = '{key_valid:   1'b1,
                                    key_code:    map.code,
                                    is_ascii:    map.ascii,
                                    scan_code:   scan_code,
                                    last_of_run: 1'b0};
               end
               if (bit_ff == kbs_pkg::LAST_KEY_BIT) begin
                  prev_wr  = 1'b1;
                  state_in = kbs_pkg::SCAN_FLUSH;
               end else begin
                  mem_rd_en = 1'b1;
                  bit_in    = bit_ff + 5'd1;
               end
            end
         end

         kbs_pkg::SCAN_FLUSH: begin
            if (slot_free) begin
               push = 1'b1;
               if (pend_valid_ff) begin
                  push_item             = pend_ff;
                  push_item.last_of_run = 1'b1;
               end else begin
                  push_item = '{key_valid: 1'b0, key_code: 8'd0, is_ascii: 1'b0,
                                scan_code: 8'd0, last_of_run: 1'b1};
               end
               pend_valid_in = 1'b0;
               state_in      = kbs_pkg::SCAN_IDLE;
            end
         end

         default: begin
            state_in = kbs_pkg::SCAN_IDLE;
         end
      endcase
   end

   `KBS_ASSERT_SAME(a_push_has_slot, clock, reset, push, slot_free, "push without free slot")
   `KBS_ASSERT_NEVER(a_no_rw_overlap, clock, reset, mem_rd_en && mem_wr_en && (mem_rd_addr == mem_wr_addr), "read and write of one key in one cycle")
   `KBS_ASSERT_SAME(a_idle_no_pending, clock, reset, state_ff == kbs_pkg::SCAN_IDLE, !pend_valid_ff, "keypress held while idle")
   `KBS_ASSERT_NEXT(a_flush_ends, clock, reset, (state_ff == kbs_pkg::SCAN_FLUSH) && slot_free, state_ff == kbs_pkg::SCAN_IDLE, "flush did not end the run")

endmodule

FILE: rtl/core/key_bitmap_scanner_with_repeat.sv
// ----------------------------------------------------------------------------
// key_bitmap_scanner_with_repeat
// Keyboard bitmap scanner with typematic repeat and scancode translation.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one 32-key word of the pressed-state bitmap, its
//   block number and a millisecond timestamp. For each request the block
//   walks the 32 keys in ascending order, one key per cycle unless stalled, through the
//   last-fire time memory, and sends every keypress on the rsp channel; the
//   final response of a request has rsp_tlast set. A request that yields no
//   keypress gives one response with the valid flag low.
//   A request is accepted, the 32 keys are walked (one time memory
//   read-modify-write per key) and a last step closes the run. The next
//   request is taken after that.
//   When the receiver stalls, the walk holds on the next keypress until the
//   output register frees up; keys that do not fire never stall.
//   The csr port writes the repeat interval in milliseconds; write it only
//   while no request is in flight.
//   Reset clears the previous bitmap, marks every key as never fired and
//   loads a repeat interval of 400 ms. No clearing pass is needed.
// ----------------------------------------------------------------------------
module key_bitmap_scanner_with_repeat #(
   parameter int NUM_BLOCKS = 8,
   parameter int TIME_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // block_index[2:0], key_word[34:3], now_ms[66:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // key_code[7:0], scan_code[15:8]
   output logic [1:0]  rsp_tuser,   // key_valid[0], is_ascii[1]
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int NUM_KEYS = NUM_BLOCKS * kbs_pkg::KEYS_PER_BLOCK;
   localparam int ADDR_W   = $clog2(NUM_KEYS);

   logic [kbs_pkg::INTERVAL_W-1:0] interval_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   kbs_pkg::rsp_item_type          rsp_item_ff, rsp_item_in;

   logic                  slot_free;
   logic                  push;
   kbs_pkg::rsp_item_type push_item;
   logic                  mem_rd_en, mem_wr_en, mem_wr_set;
   logic [ADDR_W-1:0]     mem_rd_addr, mem_wr_addr;
   logic [TIME_BITS-1:0]  mem_rd_data, mem_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= kbs_pkg::REPEAT_RESET;
      end else if (csr_wr_en) begin
         interval_ff <= csr_wr_data;
      end
   end

   // Output register: load on push, drop once taken.
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = push_item;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_item_ff.scan_code, rsp_item_ff.key_code};
   assign rsp_tuser  = {rsp_item_ff.is_ascii, rsp_item_ff.key_valid};
   assign rsp_tlast  = rsp_item_ff.last_of_run;

   kbs_scan #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .TIME_BITS  (TIME_BITS),
      .ADDR_W     (ADDR_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_block   (req_tdata[2:0]),
      .req_word    (req_tdata[34:3]),
      .req_now     (req_tdata[66:35]),
      .interval    (interval_ff),
      .slot_free   (slot_free),
      .push        (push),
      .push_item   (push_item),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_wr_set  (mem_wr_set)
   );

   kbs_time_mem #(
      .DEPTH  (NUM_KEYS),
      .ADDR_W (ADDR_W),
      .DATA_W (TIME_BITS)
   ) u_time_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .wr_set  (mem_wr_set)
   );

endmodule
